// File: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CBIP_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("cbip assertion failed");

// checked at every edge, reset included
`define CBIP_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("cbip assertion failed");

`endif

// File: rtl/core/cbip_pkg.sv
// types and constants for the custom base integer parser
`timescale 1ns / 1ps

package cbip_pkg;

  localparam int ACC_WIDTH_DEF    = 32;
  localparam int SYMBOL_SPACE_DEF = 128;

  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [DIGIT_W-1:0] MAX_LEN = 7'd127;
  localparam logic [DIGIT_W-1:0] MIN_LEN = 7'd2;

  localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS     = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'd45;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_STRING = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ALPHA  = 2'd1,
    ST_BAD_PREFIX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_REST  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                str;
    logic [CHAR_W-1:0]   char_code;
    logic                last;
    logic                is_digit;
    logic                alph_ok;
    logic [DIGIT_W-1:0]  alph_len;
  } stage_t;

endpackage

// File: rtl/core/cbip_ifs.sv
// valid/ready channel interfaces for the parser input and result
`timescale 1ns / 1ps

interface cbip_in_if;
  logic                          valid;
  logic                          ready;
  logic [cbip_pkg::MODE_W-1:0]   mode;
  logic [cbip_pkg::CHAR_W-1:0]   char_code;
  logic                          last;

  modport source (output valid, output mode, output char_code, output last, input ready);
  modport sink   (input valid, input mode, input char_code, input last, output ready);
endinterface

interface cbip_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbip_pkg::VALUE_W-1:0]  value;
  logic [cbip_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// File: rtl/core/cbip_alphabet.sv
// alphabet store, symbol lookup and input stage register
`timescale 1ns / 1ps

module cbip_alphabet #(
  parameter int SYMBOL_SPACE = cbip_pkg::SYMBOL_SPACE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic                              advance,
  input  logic [cbip_pkg::MODE_W-1:0]       in_mode,
  input  logic [cbip_pkg::CHAR_W-1:0]       in_char,
  input  logic                              in_last,
  output logic                              stage_valid,
  output cbip_pkg::stage_t                  stage,
  output logic [cbip_pkg::DIGIT_W-1:0]      stage_digit
);

  localparam int IDX_W = $clog2(SYMBOL_SPACE);

  logic [SYMBOL_SPACE-1:0]          present_r, present_nxt;
  logic [cbip_pkg::DIGIT_W-1:0]     len_r, len_nxt;
  logic                             bad_r, bad_nxt;
  logic                             stage_valid_r, stage_valid_nxt;
  cbip_pkg::stage_t                 stage_r, stage_nxt;
  logic [cbip_pkg::DIGIT_W-1:0]     digit_mem [SYMBOL_SPACE];
  logic [cbip_pkg::DIGIT_W-1:0]     digit_r;
  logic [IDX_W-1:0]                 idx;
  logic                             in_range;
  logic                             hit;
  logic                             sym_bad;
  logic                             wr_en;

  assign idx      = in_char[IDX_W-1:0];
  assign in_range = {1'b0, in_char} < (cbip_pkg::CHAR_W + 1)'(SYMBOL_SPACE);
  assign hit      = in_range && present_r[idx];
  assign sym_bad  = (in_char == cbip_pkg::CH_PLUS) || (in_char == cbip_pkg::CH_MINUS) ||
                    (in_char < cbip_pkg::CH_PRINT_LO) || (in_char > cbip_pkg::CH_PRINT_HI) ||
                    hit;

  // alphabet update
  always_comb begin
    present_nxt = present_r;
    len_nxt     = len_r;
    bad_nxt     = bad_r;
    wr_en       = 1'b0;
    if (accept) begin
      case (cbip_pkg::mode_t'(in_mode))
        cbip_pkg::MODE_CLEAR: begin
          present_nxt = '0;
          len_nxt     = '0;
          bad_nxt     = 1'b0;
        end
        cbip_pkg::MODE_APPEND: begin
          if (sym_bad) begin
            bad_nxt = 1'b1;
          end else if (len_r < cbip_pkg::MAX_LEN) begin
            present_nxt[idx] = 1'b1;
            len_nxt          = len_r + 7'd1;
            wr_en            = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stage_nxt.str       = (in_mode == cbip_pkg::MODE_STRING);
    stage_nxt.char_code = in_char;
    stage_nxt.last      = in_last;
    stage_nxt.is_digit  = hit;
    stage_nxt.alph_ok   = !bad_nxt && (len_nxt >= cbip_pkg::MIN_LEN);
    stage_nxt.alph_len  = len_nxt;
    stage_valid_nxt     = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r     <= '0;
      len_r         <= '0;
      bad_r         <= 1'b0;
      stage_valid_r <= 1'b0;
    end else begin
      present_r     <= present_nxt;
      len_r         <= len_nxt;
      bad_r         <= bad_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  // digit memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[idx] <= len_r;
    end
    if (accept) begin
      digit_r <= digit_mem[idx];
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;
  assign stage_digit = digit_r;

endmodule

// File: rtl/core/cbip_parser.sv
// parse state machine, multiply-accumulate and result register
`timescale 1ns / 1ps

module cbip_parser #(
  parameter int ACC_WIDTH = cbip_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 advance,
  input  cbip_pkg::stage_t                     stage,
  input  logic [cbip_pkg::DIGIT_W-1:0]         stage_digit,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [cbip_pkg::VALUE_W-1:0]  out_value,
  output logic [cbip_pkg::STATUS_W-1:0]        out_status
);

  cbip_pkg::phase_t                 phase_r, phase_nxt, ph_p;
  logic                             minus_r, minus_nxt, mi_p;
  logic [ACC_WIDTH-1:0]             acc_r, acc_nxt, ac_p;
  logic                             perr_r, perr_nxt, pe_p;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [cbip_pkg::VALUE_W-1:0] value_r, value_nxt;
  cbip_pkg::status_t                status_r, status_nxt;
  logic [ACC_WIDTH-1:0]             prod;
  logic [ACC_WIDTH-1:0]             mac;
  logic [ACC_WIDTH-1:0]             neg;
  logic signed [ACC_WIDTH-1:0]      signed_acc;
  logic [cbip_pkg::CHAR_W-1:0]      c;
  logic                             is_ws;
  logic                             is_sign;
  logic                             parse_en;
  logic                             finish;
  logic                             emit;
  logic                             f_perr;

  assign c        = stage.char_code;
  assign is_ws    = (c == cbip_pkg::CH_SPACE) ||
                    ((c >= cbip_pkg::CH_TAB) && (c <= cbip_pkg::CH_CR));
  assign is_sign  = (c == cbip_pkg::CH_PLUS) || (c == cbip_pkg::CH_MINUS);
  assign parse_en = stage.str && (c != cbip_pkg::CH_NUL);
  assign finish   = stage.str && ((c == cbip_pkg::CH_NUL) || stage.last);
  assign emit     = advance && finish;
  assign prod     = acc_r * ACC_WIDTH'(stage.alph_len);
  assign mac      = prod + ACC_WIDTH'(stage_digit);

  // parse step for one character
  always_comb begin
    ph_p = phase_r;
    mi_p = minus_r;
    ac_p = acc_r;
    pe_p = perr_r;
    if (parse_en) begin
      case (phase_r)
        cbip_pkg::PH_SPACE, cbip_pkg::PH_SIGN: begin
          if ((phase_r == cbip_pkg::PH_SPACE) && is_ws) begin
            ph_p = phase_r;
          end else if (is_sign) begin
            mi_p = minus_r ^ (c == cbip_pkg::CH_MINUS);
            ph_p = cbip_pkg::PH_SIGN;
          end else if (stage.is_digit) begin
            ac_p = ACC_WIDTH'(stage_digit);
            ph_p = cbip_pkg::PH_DIGIT;
          end else begin
            pe_p = 1'b1;
            ph_p = cbip_pkg::PH_REST;
          end
        end
        cbip_pkg::PH_DIGIT: begin
          if (stage.is_digit) begin
            ac_p = mac;
          end else begin
            ph_p = cbip_pkg::PH_REST;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state: end of string returns to the idle parse state
  always_comb begin
    phase_nxt = phase_r;
    minus_nxt = minus_r;
    acc_nxt   = acc_r;
    perr_nxt  = perr_r;
    if (advance && stage.str) begin
      if (finish) begin
        phase_nxt = cbip_pkg::PH_SPACE;
        minus_nxt = 1'b0;
        acc_nxt   = '0;
        perr_nxt  = 1'b0;
      end else begin
        phase_nxt = ph_p;
        minus_nxt = mi_p;
        acc_nxt   = ac_p;
        perr_nxt  = pe_p;
      end
    end
  end

  // result of a finishing transaction
  always_comb begin
    f_perr     = pe_p || (ph_p == cbip_pkg::PH_SIGN);
    neg        = '0 - ac_p;
    signed_acc = mi_p ? $signed(neg) : $signed(ac_p);
    if (!stage.alph_ok) begin
      status_nxt = cbip_pkg::ST_BAD_ALPHA;
      value_nxt  = '0;
    end else if (f_perr) begin
      status_nxt = cbip_pkg::ST_BAD_PREFIX;
      value_nxt  = '0;
    end else begin
      status_nxt = cbip_pkg::ST_OK;
      value_nxt  = cbip_pkg::VALUE_W'(signed_acc);
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cbip_pkg::PH_SPACE;
      minus_r     <= 1'b0;
      acc_r       <= '0;
      perr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      minus_r     <= minus_nxt;
      acc_r       <= acc_nxt;
      perr_r      <= perr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

// File: rtl/core/custom_base_integer_parser.sv
// top level of the custom base integer parser
// in_ch takes one transaction per byte: mode 0 clears the digit alphabet,
//   mode 1 appends char_code as the next symbol, mode 2 streams a string
//   character (a zero byte or the last flag ends the string); mode 3 is ignored
// out_ch carries one transaction per finished string: value (signed, zero on
//   error) and status (ok, invalid alphabet, malformed prefix)
// path: out_ch.valid rises once a finishing transaction has been accepted
//   and has passed the input stage register, which also holds the registered
//   digit memory read, and then the parse step with its multiply-accumulate into
//   the result register
// throughput: one transaction per cycle; in_ch.ready stays high while the
//   result register is free or being emptied in the same cycle
// stall: while out_ch.ready is low with a result pending, the input stage
//   holds one more transaction and then in_ch.ready drops
// reset: synchronous active-low rst_n empties both stages, clears the
//   alphabet and the parse state; no clearing pass, the block is ready at once
`timescale 1ns / 1ps

module custom_base_integer_parser #(
  parameter int ACC_WIDTH    = cbip_pkg::ACC_WIDTH_DEF,
  parameter int SYMBOL_SPACE = cbip_pkg::SYMBOL_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cbip_in_if.sink           in_ch,
  cbip_out_if.source        out_ch
);

  logic                             accept;
  logic                             advance;
  logic                             stage_valid;
  cbip_pkg::stage_t                 stage;
  logic [cbip_pkg::DIGIT_W-1:0]     stage_digit;
  logic                             out_valid;

  assign advance      = stage_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !stage_valid || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  cbip_alphabet #(
    .SYMBOL_SPACE (SYMBOL_SPACE)
  ) u_alphabet (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .advance     (advance),
    .in_mode     (in_ch.mode),
    .in_char     (in_ch.char_code),
    .in_last     (in_ch.last),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_digit (stage_digit)
  );

  cbip_parser #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .stage       (stage),
    .stage_digit (stage_digit),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_value   (out_ch.value),
    .out_status  (out_ch.status)
  );

endmodule

// File: rtl/core/cbip_checker.sv
// port-level checks for the custom base integer parser
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbip_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [cbip_pkg::VALUE_W-1:0]  out_value,
  input logic [cbip_pkg::STATUS_W-1:0]        out_status
);

  `CBIP_ASSERT_ALWAYS(a_reset_empties_output, clk, !rst_n |=> !out_valid)
  `CBIP_ASSERT(a_status_known, clk, rst_n, out_valid |-> (out_status == cbip_pkg::ST_OK || out_status == cbip_pkg::ST_BAD_ALPHA || out_status == cbip_pkg::ST_BAD_PREFIX))
  `CBIP_ASSERT(a_error_zero_value, clk, rst_n, (out_valid && out_status != cbip_pkg::ST_OK) |-> (out_value == '0))
  `CBIP_ASSERT(a_stall_holds, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)))

endmodule

bind custom_base_integer_parser cbip_checker u_cbip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

// File: tb/parse_result_checker.sv
// checker that predicts the parser results and compares them with the result channel
`timescale 1ns / 1ps

module parse_result_checker
  import cbip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cbip_in_if          in_ch,
  cbip_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } parse_result_t;

  logic [DIGIT_W-1:0] digit_of    [SYMBOL_SPACE_DEF];
  logic               in_alphabet [SYMBOL_SPACE_DEF];
  logic [DIGIT_W-1:0] alpha_len;
  logic               alpha_invalid;
  phase_t             scan_phase;
  logic               negate;
  logic [VALUE_W-1:0] acc;
  logic               prefix_bad;
  parse_result_t      expected_results [$];
  int unsigned        errors = 0;

  task automatic restart_scan();
    scan_phase = PH_SPACE;
    negate     = 1'b0;
    acc        = '0;
    prefix_bad = 1'b0;
  endtask

  task automatic close_string();
    parse_result_t r;
    if (scan_phase == PH_SIGN) prefix_bad = 1'b1;
    r.value = '0;
    if (alpha_invalid || alpha_len < MIN_LEN) begin
      r.status = ST_BAD_ALPHA;
    end else if (prefix_bad) begin
      r.status = ST_BAD_PREFIX;
    end else begin
      r.status = ST_OK;
      r.value  = negate ? (~acc + 1'b1) : acc;
    end
    expected_results.push_back(r);
    restart_scan();
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c);
    logic               hit;
    logic [DIGIT_W-1:0] digit;
    hit   = !c[7] && in_alphabet[c[6:0]];
    digit = digit_of[c[6:0]];
    if (scan_phase == PH_REST) return;
    if (scan_phase == PH_DIGIT) begin
      if (hit) acc = acc * VALUE_W'(alpha_len) + VALUE_W'(digit);
      else scan_phase = PH_REST;
    end else if (scan_phase == PH_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      // leading whitespace is skipped
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (c == CH_MINUS) negate = !negate;
      scan_phase = PH_SIGN;
    end else if (hit) begin
      acc        = VALUE_W'(digit);
      scan_phase = PH_DIGIT;
    end else begin
      prefix_bad = 1'b1;
      scan_phase = PH_REST;
    end
  endtask

  task automatic absorb_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                             input logic l);
    case (m)
      MODE_CLEAR: begin
        for (int i = 0; i < SYMBOL_SPACE_DEF; i++) in_alphabet[i] = 1'b0;
        alpha_len     = '0;
        alpha_invalid = 1'b0;
      end
      MODE_APPEND: begin
        if (c == CH_PLUS || c == CH_MINUS || c < CH_PRINT_LO || c > CH_PRINT_HI ||
            in_alphabet[c[6:0]]) begin
          alpha_invalid = 1'b1;
        end else if (alpha_len < MAX_LEN) begin
          in_alphabet[c[6:0]] = 1'b1;
          digit_of[c[6:0]]    = alpha_len;
          alpha_len           = alpha_len + 1'b1;
        end
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          close_string();
        end else begin
          scan_char(c);
          if (l) close_string();
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    parse_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SYMBOL_SPACE_DEF; i++) begin
        in_alphabet[i] = 1'b0;
        digit_of[i]    = '0;
      end
      alpha_len     = '0;
      alpha_invalid = 1'b0;
      restart_scan();
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got value %0d status %0d",
                   $time, out_ch.value, out_ch.status);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value !== want.value || out_ch.status !== want.status) begin
            errors++;
            $display("%0t: result mismatch, expected value %0d status %0d, got value %0d status %0d",
                     $time, want.value, want.status, out_ch.value, out_ch.status);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) absorb_item(in_ch.mode, in_ch.char_code, in_ch.last);
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

// File: tb/testbench.sv
// top of the parser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import cbip_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;
  localparam int unsigned       CYCLE_LIMIT     = 200000;
  localparam int unsigned       DRAIN_CYCLES    = 8;
  localparam int unsigned       ITEMS_PER_PHASE = 125;
  localparam int unsigned       MAX_SYMBOLS     = 93;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned pending_count;
  logic [CHAR_W-1:0] alphabet [$];
  logic              symbol_taken [SYMBOL_SPACE_DEF];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cbip_in_if  in_ch ();
  cbip_out_if out_ch ();

  custom_base_integer_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [CHAR_W-1:0] rand_byte(input int unsigned lo, input int unsigned hi);
    return CHAR_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                           input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.char_code <= c;
    in_ch.last      <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (m != MODE_UNUSED) items_sent++;
  endtask

  task automatic add_symbol();
    logic [CHAR_W-1:0] c;
    do c = rand_byte(CH_PRINT_LO, CH_PRINT_HI);
    while (c == CH_PLUS || c == CH_MINUS || symbol_taken[c[6:0]]);
    symbol_taken[c[6:0]] = 1'b1;
    alphabet.push_back(c);
    send_item(MODE_APPEND, c, rand_bit());
  endtask

  initial begin
    int unsigned       base;
    int                n;
    int                k;
    int                roll;
    logic [MODE_W-1:0] m;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] text [$];
    logic              zero_end;

    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_CLEAR;
    in_ch.char_code = CH_NUL;
    in_ch.last      = 1'b0;
    rst_n           = 1'b0;
    for (int i = 0; i < SYMBOL_SPACE_DEF; i++) symbol_taken[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // empty alphabet, bad and repeated symbols, single-symbol alphabet
    send_item(MODE_STRING, CH_NUL, 1'b0);
    send_item(MODE_CLEAR, CH_NUL, 1'b0);
    send_item(MODE_APPEND, CH_PLUS, 1'b0);
    send_item(MODE_APPEND, "z", 1'b0);
    send_item(MODE_APPEND, "z", 1'b0);
    send_item(MODE_STRING, "z", 1'b1);
    send_item(MODE_CLEAR, CH_NUL, 1'b1);
    send_item(MODE_APPEND, "x", 1'b0);
    send_item(MODE_STRING, "x", 1'b1);
    send_item(MODE_CLEAR, 8'hFF, 1'b0);
    send_item(MODE_APPEND, "0", 1'b0);
    send_item(MODE_APPEND, "1", 1'b0);
    // whitespace, signs, alphabet growing mid-string, trailing junk
    send_item(MODE_STRING, CH_SPACE, 1'b0);
    send_item(MODE_STRING, CH_TAB, 1'b0);
    send_item(MODE_STRING, CH_MINUS, 1'b0);
    send_item(MODE_STRING, CH_PLUS, 1'b0);
    send_item(MODE_STRING, "1", 1'b0);
    send_item(MODE_APPEND, "2", 1'b0);
    send_item(MODE_STRING, "2", 1'b0);
    send_item(MODE_STRING, "x", 1'b0);
    send_item(MODE_STRING, "1", 1'b1);
    // sign only, high byte prefix, unused mode, empty string
    send_item(MODE_STRING, CH_MINUS, 1'b1);
    send_item(MODE_STRING, 8'hFF, 1'b1);
    send_item(MODE_UNUSED, "1", 1'b1);
    send_item(MODE_STRING, CH_NUL, 1'b1);
    send_item(MODE_APPEND, CH_PRINT_HI, 1'b0);
    send_item(MODE_APPEND, 8'd127, 1'b0);

    base = items_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 62; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 62; end
        default: begin send_gap_pct = 15; stall_pct = 15; end
      endcase
      while (items_sent < base + ITEMS_PER_PHASE * (p + 1)) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          case ($urandom_range(0, 2))
            0: m = MODE_APPEND;
            1: m = MODE_STRING;
            default: m = MODE_UNUSED;
          endcase
          send_item(m, rand_byte(0, 255), rand_bit());
        end else if (roll < 30 || alphabet.size() == 0) begin
          send_item(MODE_CLEAR, rand_byte(0, 255), rand_bit());
          alphabet.delete();
          for (int i = 0; i < SYMBOL_SPACE_DEF; i++) symbol_taken[i] = 1'b0;
          k = $urandom_range(0, 19);
          n = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? MAX_SYMBOLS : $urandom_range(2, 16);
          repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
              case ($urandom_range(0, 3))
                0: c = rand_bit() ? CH_PLUS : CH_MINUS;
                1: c = rand_byte(0, 31);
                2: c = rand_byte(127, 255);
                default: c = (alphabet.size() != 0) ?
                             alphabet[$urandom_range(0, alphabet.size() - 1)] : CH_MINUS;
              endcase
              send_item(MODE_APPEND, c, rand_bit());
            end else if (alphabet.size() < MAX_SYMBOLS) begin
              add_symbol();
            end
          end
        end else begin
          text.delete();
          repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(0, 5);
            text.push_back((k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k));
          end
          repeat ($urandom_range(0, 3)) text.push_back(rand_bit() ? CH_MINUS : CH_PLUS);
          if ($urandom_range(0, 7) == 0) text.push_back(rand_byte(1, 255));
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
          repeat (n) text.push_back(alphabet[$urandom_range(0, alphabet.size() - 1)]);
          repeat ($urandom_range(0, 3)) text.push_back(rand_byte(1, 255));
          zero_end = (text.size() == 0) || rand_bit();
          if (zero_end) text.push_back(CH_NUL);
          foreach (text[i]) begin
            if ($urandom_range(0, 49) == 0 && alphabet.size() < MAX_SYMBOLS) add_symbol();
            send_item(MODE_STRING, text[i],
                      (i == text.size() - 1) ? (zero_end ? rand_bit() : 1'b1) : 1'b0);
          end
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
